[src/u8u16_pkg.sv]
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
package u8u16_pkg;

    // Result kinds carried on the master tuser
    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_DONE     = 2'd1,
        KIND_INVALID  = 2'd2,
        KIND_OVERFLOW = 2'd3
    } kind_t;

    // Register map
    localparam logic        REG_CAPACITY   = 1'b0;
    localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

    // Code point limits
    localparam logic [20:0] SURR_LO   = 21'h00D800;
    localparam logic [20:0] SURR_END  = 21'h00E000;
    localparam logic [20:0] BMP_END   = 21'h010000;
    localparam logic [20:0] CP_MAX    = 21'h10FFFF;
    localparam logic [15:0] HI_SURR   = 16'hD800;
    localparam logic [15:0] LO_SURR   = 16'hDC00;

    // Per-string decoder state
    typedef struct packed {
        logic [20:0] code_accum;
        logic [1:0]  bytes_pending;
        logic [15:0] word_count;
        logic        discarding;
    } dec_state_t;

    // One result beat
    typedef struct packed {
        logic [15:0] code_unit;
        kind_t       kind;
        logic [15:0] words_done;
        logic        last_of_run;
    } result_t;

endpackage

[src/u8u16_step.sv]
// Decoder step: next state and up to two result beats for one input byte.
module u8u16_step
    import u8u16_pkg::*;
(
    input  logic [7:0]  in_byte,
    input  dec_state_t  st,
    input  logic [15:0] capacity,
    output dec_state_t  st_next,
    output logic [1:0]  res_cnt,
    output result_t     res0,
    output result_t     res1
);

    logic [20:0] acc_shift;
    logic [1:0]  pend_dec;
    logic [20:0] pair_off;
    logic        cp_bad;
    logic        room_one;
    logic        room_two;

    // Accumulated code point after a continuation byte
    assign acc_shift = {st.code_accum[14:0], in_byte[5:0]};
    assign pend_dec  = st.bytes_pending - 2'd1;
    assign pair_off  = acc_shift - BMP_END;
    assign cp_bad    = ((acc_shift >= SURR_LO) && (acc_shift < SURR_END))
                       || (acc_shift == 21'd0) || (acc_shift > CP_MAX);
    assign room_one  = st.word_count < capacity;
    assign room_two  = ({1'b0, st.word_count} + 17'd1) < {1'b0, capacity};

    always_comb
    begin
        st_next = st;
        res_cnt = 2'd0;
        res0    = '{code_unit: 16'd0, kind: KIND_DATA, words_done: 16'd0, last_of_run: 1'b1};
        res1    = res0;

        if (in_byte == 8'd0)
        begin
            // Terminator: report (unless discarding) and start a fresh string
            st_next = '0;
            if (st.discarding)
            begin
                res_cnt = 2'd0;
            end
            else if (st.bytes_pending != 2'd0)
            begin
                res0.kind = KIND_INVALID;
                res_cnt   = 2'd1;
            end
            else if (!room_one)
            begin
                res0.kind = KIND_OVERFLOW;
                res_cnt   = 2'd1;
            end
            else
            begin
                res0.kind       = KIND_DONE;
                res0.words_done = st.word_count;
                res_cnt         = 2'd1;
            end
        end
        else if (st.discarding)
        begin
            res_cnt = 2'd0;
        end
        else if (st.bytes_pending != 2'd0)
        begin
            // Continuation expected
            if (in_byte[7:6] != 2'b10)
            begin
                res0.kind             = KIND_INVALID;
                res_cnt               = 2'd1;
                st_next.discarding    = 1'b1;
                st_next.bytes_pending = 2'd0;
                st_next.code_accum    = 21'd0;
            end
            else if (pend_dec != 2'd0)
            begin
                st_next.code_accum    = acc_shift;
                st_next.bytes_pending = pend_dec;
            end
            else if (cp_bad || !room_one)
            begin
                res0.kind             = cp_bad ? KIND_INVALID : KIND_OVERFLOW;
                res_cnt               = 2'd1;
                st_next.discarding    = 1'b1;
                st_next.bytes_pending = 2'd0;
                st_next.code_accum    = 21'd0;
            end
            else if (acc_shift < BMP_END)
            begin
                res0.code_unit        = acc_shift[15:0];
                res_cnt               = 2'd1;
                st_next.code_accum    = acc_shift;
                st_next.bytes_pending = 2'd0;
                st_next.word_count    = st.word_count + 16'd1;
            end
            else if (!room_two)
            begin
                res0.kind             = KIND_OVERFLOW;
                res_cnt               = 2'd1;
                st_next.discarding    = 1'b1;
                st_next.bytes_pending = 2'd0;
                st_next.code_accum    = 21'd0;
            end
            else
            begin
                // Surrogate pair
                res0.code_unit        = HI_SURR + {6'd0, pair_off[19:10]};
                res0.last_of_run      = 1'b0;
                res1.code_unit        = LO_SURR + {6'd0, pair_off[9:0]};
                res_cnt               = 2'd2;
                st_next.code_accum    = acc_shift;
                st_next.bytes_pending = 2'd0;
                st_next.word_count    = st.word_count + 16'd2;
            end
        end
        else if (in_byte[7:3] == 5'b11110)
        begin
            st_next.code_accum    = {18'd0, in_byte[2:0]};
            st_next.bytes_pending = 2'd3;
        end
        else if (in_byte[7:4] == 4'b1110)
        begin
            st_next.code_accum    = {17'd0, in_byte[3:0]};
            st_next.bytes_pending = 2'd2;
        end
        else if (in_byte[7:5] == 3'b110)
        begin
            st_next.code_accum    = {16'd0, in_byte[4:0]};
            st_next.bytes_pending = 2'd1;
        end
        else if (in_byte[7])
        begin
            // Stray continuation or 11111xxx lead
            res0.kind             = KIND_INVALID;
            res_cnt               = 2'd1;
            st_next.discarding    = 1'b1;
            st_next.bytes_pending = 2'd0;
            st_next.code_accum    = 21'd0;
        end
        else if (!room_one)
        begin
            res0.kind             = KIND_OVERFLOW;
            res_cnt               = 2'd1;
            st_next.discarding    = 1'b1;
            st_next.bytes_pending = 2'd0;
            st_next.code_accum    = 21'd0;
        end
        else
        begin
            // Plain ASCII
            res0.code_unit     = {8'd0, in_byte};
            res_cnt            = 2'd1;
            st_next.word_count = st.word_count + 16'd1;
        end
    end

endmodule

[src/u8u16_fifo.sv]
// Four-entry result queue taking up to two beats in and one beat out per cycle.
module u8u16_fifo
    import u8u16_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_cnt,
    input  result_t    push0,
    input  result_t    push1,
    input  logic       pop,
    output logic       room2,
    output logic       head_valid,
    output result_t    head
);

    result_t    entry_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_reg;
    logic [1:0] rd_ptr_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic [1:0] wr_ptr_inc;

    assign wr_ptr_inc = wr_ptr_reg + 2'd1;
    assign room2      = count_reg <= 3'd2;
    assign head_valid = count_reg != 3'd0;
    assign head       = entry_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push_cnt;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push_cnt} - {2'd0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2)
        begin
            entry_reg[wr_ptr_inc] <= push1;
        end
    end

endmodule

[src/utf8_to_utf16_transcoder_core.sv]
// Top level of the UTF-8 to UTF-16 transcoder: config register, decoder state, result queue.
//
//  Channel | Dir | Beat contents
//  --------+-----+---------------------------------------------------------
//  s_*     | in  | tdata[7:0] in_byte
//  m_*     | out | tdata[15:0] code_unit, [31:16] words_done; tuser kind; tlast last_of_run
//  APB     | in  | reg 0 at byte address 0: capacity_words[15:0]
//
//  One byte is taken per cycle while s_tready is high; each byte is decoded in the cycle it is
//  taken and its beats are registered in the queue, behind any beats already there. A surrogate
//  pair leaves as two beats but takes four input bytes, so with m_tready held high the
//  queue stays at two beats or fewer and the input never stalls.
//  s_tready is high while the queue holds two beats or fewer; m_tready stalls back up into it.
//  Reset: capacity 65535, decoder state cleared, queue empty.
module utf8_to_utf16_transcoder_core
    import u8u16_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] code_unit, [31:16] words_done
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast,   // last_of_run
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] capacity_reg;
    dec_state_t  state_reg;
    dec_state_t  state_next;
    dec_state_t  step_state;
    logic [1:0]  step_cnt;
    logic [1:0]  push_cnt;
    result_t     res0;
    result_t     res1;
    result_t     head;
    logic        in_beat;

    assign pready  = 1'b1;
    assign in_beat = s_tvalid && s_tready;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_CAPACITY))
        begin
            capacity_reg <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == REG_CAPACITY) ? {16'd0, capacity_reg} : 32'd0;

    // Decoder
    u8u16_step u_step (
        .in_byte  (s_tdata),
        .st       (state_reg),
        .capacity (capacity_reg),
        .st_next  (step_state),
        .res_cnt  (step_cnt),
        .res0     (res0),
        .res1     (res1)
    );

    assign state_next = in_beat ? step_state : state_reg;
    assign push_cnt   = in_beat ? step_cnt : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Result queue
    u8u16_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cnt   (push_cnt),
        .push0      (res0),
        .push1      (res1),
        .pop        (m_tvalid && m_tready),
        .room2      (s_tready),
        .head_valid (m_tvalid),
        .head       (head)
    );

    assign m_tdata = {head.words_done, head.code_unit};
    assign m_tuser = head.kind;
    assign m_tlast = head.last_of_run;

endmodule

[test/u8u16_stream_checker.sv]
// Stream checker for the UTF-8 to UTF-16 transcoder: tracks capacity writes, predicts and compares result beats.
module u8u16_stream_checker
    import u8u16_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [15:0] code_unit, [31:16] words_done
    input  logic [1:0]  m_tuser,   // [1:0] kind
    input  logic        m_tlast,   // last_of_run
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatches,
    output int          units_owed
);

    localparam logic [2:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};
    localparam int         REPORT_LIMIT  = 10;

    // Shadow of the capacity register and of the per-string decoder
    logic [15:0] capacity      = CAPACITY_RESET;
    logic [20:0] cp_build      = '0;
    logic [1:0]  cont_left     = '0;
    logic [15:0] units_written = '0;
    logic        skipping      = 1'b0;

    result_t owed_beats[$];
    int      errors = 0;

    function automatic void push_unit(input logic [15:0] unit, input kind_t kind,
                                      input logic [15:0] done, input logic last);
        result_t r;
        r.code_unit   = unit;
        r.kind        = kind;
        r.words_done  = done;
        r.last_of_run = last;
        owed_beats.push_back(r);
    endfunction

    // Error beat, then drop bytes until the terminator
    function automatic void abandon_string(input kind_t kind);
        push_unit(16'h0000, kind, 16'h0000, 1'b1);
        skipping  = 1'b1;
        cont_left = '0;
        cp_build  = '0;
    endfunction

    function automatic void emit_code_point(input logic [20:0] cp);
        logic [20:0] offs;
        if ((cp >= SURR_LO && cp < SURR_END) || cp == '0 || cp > CP_MAX)
            abandon_string(KIND_INVALID);
        else if (units_written >= capacity)
            abandon_string(KIND_OVERFLOW);
        else if (cp < BMP_END)
        begin
            push_unit(cp[15:0], KIND_DATA, 16'h0000, 1'b1);
            units_written = units_written + 16'd1;
        end
        else if ({1'b0, units_written} + 17'd1 >= {1'b0, capacity})
            abandon_string(KIND_OVERFLOW);
        else
        begin
            offs = cp - BMP_END;
            push_unit(HI_SURR + {6'd0, offs[19:10]}, KIND_DATA, 16'h0000, 1'b0);
            push_unit(LO_SURR + {6'd0, offs[9:0]}, KIND_DATA, 16'h0000, 1'b1);
            units_written = units_written + 16'd2;
        end
    endfunction

    // Predict the beats caused by one accepted input byte
    function automatic void transcode_byte(input logic [7:0] b);
        if (b == 8'h00)
        begin
            if (skipping)
                ;
            else if (cont_left != '0)
                push_unit(16'h0000, KIND_INVALID, 16'h0000, 1'b1);
            else if (units_written >= capacity)
                push_unit(16'h0000, KIND_OVERFLOW, 16'h0000, 1'b1);
            else
                push_unit(16'h0000, KIND_DONE, units_written, 1'b1);
            cp_build      = '0;
            cont_left     = '0;
            units_written = '0;
            skipping      = 1'b0;
        end
        else if (skipping)
            ;
        else if (cont_left != '0)
        begin
            if (b[7:6] != 2'b10)
                abandon_string(KIND_INVALID);
            else
            begin
                cp_build  = {cp_build[14:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == '0)
                    emit_code_point(cp_build);
            end
        end
        else if (b[7:3] == 5'b11110)
        begin
            cp_build  = {18'd0, b[2:0]};
            cont_left = 2'd3;
        end
        else if (b[7:4] == 4'b1110)
        begin
            cp_build  = {17'd0, b[3:0]};
            cont_left = 2'd2;
        end
        else if (b[7:5] == 3'b110)
        begin
            cp_build  = {16'd0, b[4:0]};
            cont_left = 2'd1;
        end
        else if (b[7])
            abandon_string(KIND_INVALID);
        else if (units_written >= capacity)
            abandon_string(KIND_OVERFLOW);
        else
        begin
            push_unit({8'h00, b}, KIND_DATA, 16'h0000, 1'b1);
            units_written = units_written + 16'd1;
        end
    endfunction

    // Observe register writes, result beats and input beats at each edge
    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            capacity      = CAPACITY_RESET;
            cp_build      = '0;
            cont_left     = '0;
            units_written = '0;
            skipping      = 1'b0;
            owed_beats.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == CAPACITY_ADDR)
                capacity = pwdata[15:0];

            if (m_tvalid && m_tready)
            begin
                got.code_unit   = m_tdata[15:0];
                got.kind        = kind_t'(m_tuser);
                got.words_done  = m_tdata[31:16];
                got.last_of_run = m_tlast;
                if (owed_beats.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("%0t: unexpected beat unit=%h kind=%0d done=%0d last=%b",
                                 $realtime, got.code_unit, m_tuser, got.words_done,
                                 got.last_of_run);
                end
                else
                begin
                    want = owed_beats.pop_front();
                    if (got.code_unit !== want.code_unit || got.kind !== want.kind ||
                        got.words_done !== want.words_done ||
                        got.last_of_run !== want.last_of_run)
                    begin
                        errors++;
                        if (errors <= REPORT_LIMIT)
                            $display("%0t: beat mismatch exp unit=%h kind=%0d done=%0d last=%b",
                                     $realtime, want.code_unit, want.kind, want.words_done,
                                     want.last_of_run, " got unit=%h kind=%0d done=%0d last=%b",
                                     got.code_unit, m_tuser, got.words_done, got.last_of_run);
                    end
                end
            end

            if (s_tvalid && s_tready)
                transcode_byte(s_tdata);
        end
        mismatches <= errors;
        units_owed <= owed_beats.size();
    end

endmodule

[test/tb_utf8_to_utf16_transcoder_core.sv]
// Testbench top for the UTF-8 to UTF-16 transcoder: clock, reset, stimulus, capacity writes, verdict.
module tb_utf8_to_utf16_transcoder_core;
    import u8u16_pkg::*;

    localparam int RANDOM_BYTES  = 800;
    localparam int RUN_LIMIT     = 400000;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 16;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'd0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [31:0] m_tdata;
    wire  [1:0]  m_tuser;
    wire         m_tlast;
    wire  [31:0] prdata;
    wire         pready;

    int fails;
    int owed;
    int cycles       = 0;
    int burst_left   = 0;
    int random_bytes = 0;
    int stall_tick   = 0;
    logic [1:0] stall_mode = 2'd0;

    logic [7:0] line_bytes[$];

    // Hand-picked strings: field extremes, longest forms, then one string per error case
    logic [7:0] directed_stream [0:35] = '{
        8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF,
        8'h00,
        8'hED, 8'hA0, 8'h80, 8'h41, 8'h00,      // surrogate, then bytes while discarding
        8'hC0, 8'h80, 8'h00,                    // encoded zero
        8'hF4, 8'h90, 8'h80, 8'h80, 8'h00,      // above 0x10FFFF
        8'hFF, 8'h00,                           // bad lead
        8'hC2, 8'h41, 8'h00,                    // missing continuation
        8'hE0, 8'h80, 8'h00,                    // terminator inside a sequence
        8'h80, 8'h00                            // stray continuation as lead
    };

    utf8_to_utf16_transcoder_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    u8u16_stream_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .mismatches (fails),
        .units_owed (owed)
    );

    // Clock, period 4
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver: picks a new random stall mode whenever its tick counter runs out
    always @(posedge clk)
    begin
        if (stall_tick == 0)
        begin
            stall_mode <= 2'($urandom_range(0, 3));
            stall_tick <= $urandom_range(20, 150);
        end
        else
            stall_tick <= stall_tick - 1;
        case (stall_mode)
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= ($urandom_range(0, 3) != 0);
            2'd2:    m_tready <= ((stall_tick % 5) < 2);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // One input beat; the sender runs in bursts with random gaps between them
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                     : $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        burst_left--;
    endtask

    // Capacity write once the block has gone quiet
    task automatic set_capacity(input logic [15:0] value);
        logic [15:0] upper;
        upper = 16'($urandom);
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (owed == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_CAPACITY, 2'b00};
        pwdata  <= {upper, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic void append_utf8(input logic [20:0] cp, input int n_bytes);
        case (n_bytes)
            1:
                line_bytes.push_back({1'b0, cp[6:0]});
            2:
            begin
                line_bytes.push_back({3'b110, cp[10:6]});
                line_bytes.push_back({2'b10, cp[5:0]});
            end
            3:
            begin
                line_bytes.push_back({4'b1110, cp[15:12]});
                line_bytes.push_back({2'b10, cp[11:6]});
                line_bytes.push_back({2'b10, cp[5:0]});
            end
            default:
            begin
                line_bytes.push_back({5'b11110, cp[20:18]});
                line_bytes.push_back({2'b10, cp[17:12]});
                line_bytes.push_back({2'b10, cp[11:6]});
                line_bytes.push_back({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    // Well-formed character, overlong non-zero forms included
    function automatic void add_good_char();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            append_utf8(21'($urandom_range(1, 127)), 1);
        else if (pick < 60)
            append_utf8(21'($urandom_range(128, 2047)), 2);
        else if (pick < 75)
            append_utf8(21'($urandom_range(0, 1) ? $urandom_range(16'h0800, 16'hD7FF)
                                                 : $urandom_range(16'hE000, 16'hFFFF)), 3);
        else if (pick < 92)
            append_utf8(21'($urandom_range(21'h10000, 21'h10FFFF)), 4);
        else
            append_utf8(21'($urandom_range(1, 127)), $urandom_range(2, 4));
    endfunction

    // Broken character of one kind or another, or a random single byte that may be valid
    function automatic void add_faulty_char();
        case ($urandom_range(0, 6))
            0: line_bytes.push_back(8'($urandom_range(1, 255)));
            1: append_utf8(21'($urandom_range(16'hD800, 16'hDFFF)), 3);
            2: append_utf8(21'd0, $urandom_range(2, 4));
            3: append_utf8(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
            4:
            begin
                append_utf8(21'($urandom_range(21'h10000, 21'h10FFFF)), 4);
                void'(line_bytes.pop_back());
            end
            5: line_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
            default: line_bytes.push_back(8'($urandom_range(8'hF8, 8'hFF)));
        endcase
    endfunction

    // One terminated string; most are clean, some carry faults
    task automatic send_random_line();
        int n_chars;
        bit tidy;
        tidy    = ($urandom_range(0, 9) < 7);
        n_chars = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 24) : $urandom_range(0, 10);
        repeat (n_chars)
        begin
            if (!tidy && $urandom_range(0, 3) == 0)
                add_faulty_char();
            else
                add_good_char();
        end
        line_bytes.push_back(8'h00);
        foreach (line_bytes[i])
            send_byte(line_bytes[i]);
        random_bytes += line_bytes.size();
        line_bytes.delete();
    endtask

    function automatic logic [15:0] pick_capacity();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'd2;
            3:       return 16'($urandom_range(3, 12));
            4, 5:    return 16'($urandom_range(13, 40));
            6:       return 16'hFFFE;
            default: return 16'hFFFF;
        endcase
    endfunction

    initial
    begin
        int phase_end;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings at the reset capacity
        foreach (directed_stream[i])
            send_byte(directed_stream[i]);

        // Zero capacity: data overflows, then an empty string's terminator overflows too
        set_capacity(16'd0);
        send_byte(8'h41);
        send_byte(8'h00);
        send_byte(8'h00);

        // Capacity two: pair fits, terminator overflows; AB likewise; then A fits
        set_capacity(16'd2);
        send_byte(8'hF0);
        send_byte(8'h90);
        send_byte(8'h80);
        send_byte(8'h80);
        send_byte(8'h00);
        send_byte(8'h41);
        send_byte(8'h42);
        send_byte(8'h00);
        send_byte(8'h41);
        send_byte(8'h00);
        set_capacity(CAPACITY_RESET);

        // Random strings in phases of differing capacity
        while (random_bytes < RANDOM_BYTES)
        begin
            set_capacity(pick_capacity());
            phase_end = random_bytes + $urandom_range(60, 140);
            while (random_bytes < phase_end)
                send_random_line();
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (owed == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[files.f]
src/u8u16_pkg.sv
src/u8u16_step.sv
src/u8u16_fifo.sv
src/utf8_to_utf16_transcoder_core.sv
test/u8u16_stream_checker.sv
test/tb_utf8_to_utf16_transcoder_core.sv
